### rtl/spb_pkg.sv
// ----------------------------------------------------------------------------
// spb_pkg
// Shared widths, constants and types for the spectral peak block.
// ----------------------------------------------------------------------------
package spb_pkg;

    localparam int DATA_W      = 16;
    localparam int OUT_W       = 10;
    localparam int POW_W       = 32;
    localparam int RATIO_W     = 16;
    localparam int RSQ_W       = 2 * RATIO_W;
    localparam int PROD_W      = POW_W + RSQ_W;
    localparam int MAX_BINS_DEF = 1024;
    localparam int Q_DEPTH     = 4;

    // ratio of 100 in Q8.8, and its square
    localparam logic [RATIO_W-1:0] DEFAULT_RATIO = 16'd25600;
    localparam logic [RSQ_W-1:0]   DEFAULT_RSQ   = 32'd655360000;

    typedef struct packed {
        logic [POW_W-1:0] power;
        logic             last;
    } t_entry;

endpackage

### rtl/spb_bin_if.sv
// ----------------------------------------------------------------------------
// spb_bin_if
// Bin channel: one spectral bin per transaction.
// ----------------------------------------------------------------------------
interface spb_bin_if;
    import spb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] real_part;
    logic signed [DATA_W-1:0] imag_part;
    logic                     last_bin;

    modport source (output valid, output real_part, output imag_part, output last_bin,
                    input ready);
    modport sink   (input valid, input real_part, input imag_part, input last_bin,
                    output ready);
endinterface

### rtl/spb_res_if.sv
// ----------------------------------------------------------------------------
// spb_res_if
// Result channel: strongest and highest significant bin of a frame.
// ----------------------------------------------------------------------------
interface spb_res_if;
    import spb_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] strongest_bin;
    logic [OUT_W-1:0] highest_significant_bin;

    modport source (output valid, output strongest_bin, output highest_significant_bin,
                    input ready);
    modport sink   (input valid, input strongest_bin, input highest_significant_bin,
                    output ready);
endinterface

### rtl/spb_cfg_if.sv
// ----------------------------------------------------------------------------
// spb_cfg_if
// Configuration write channel for the ratio register.
// ----------------------------------------------------------------------------
interface spb_cfg_if;
    import spb_pkg::*;

    logic               valid;
    logic               ready;
    logic [RATIO_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/spb_front.sv
// ----------------------------------------------------------------------------
// spb_front
// Accepts bins and turns each into a squared magnitude for the queue.
// ----------------------------------------------------------------------------
module spb_front
    import spb_pkg::*;
(
    spb_bin_if.sink i_bin,
    input  logic    i_full,
    output logic    o_push,
    output t_entry  o_entry
);

    logic signed [2*DATA_W-1:0] sq_re;
    logic signed [2*DATA_W-1:0] sq_im;

    assign i_bin.ready = !i_full;
    assign o_push      = i_bin.valid && !i_full;

    // both squares are non-negative and their sum stays below 2^31 + 1
    assign sq_re = (2*DATA_W)'(i_bin.real_part) * (2*DATA_W)'(i_bin.real_part);
    assign sq_im = (2*DATA_W)'(i_bin.imag_part) * (2*DATA_W)'(i_bin.imag_part);

    assign o_entry.power = POW_W'($unsigned(sq_re)) + POW_W'($unsigned(sq_im));
    assign o_entry.last  = i_bin.last_bin;

endmodule

### rtl/spb_fifo.sv
// ----------------------------------------------------------------------------
// spb_fifo
// Short queue between front and back.
// ----------------------------------------------------------------------------
module spb_fifo
    import spb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_data,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_data,
    input  logic   i_pop
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_entry             r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("push without pop did not grow the queue");

    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

endmodule

### rtl/spb_back.sv
// ----------------------------------------------------------------------------
// spb_back
// Tracks peak and significance per frame and drives the result register.
// ----------------------------------------------------------------------------
module spb_back
    import spb_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spb_cfg_if.sink   i_cfg,
    input  logic      i_entry_valid,
    input  t_entry    i_entry,
    output logic      o_pop,
    spb_res_if.source o_res
);

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BINS - 1);

    logic [RSQ_W-1:0]  r_rsq;
    logic [POW_W-1:0]  r_peak;
    logic [IDX_W-1:0]  r_bin_cnt;
    logic [IDX_W-1:0]  r_peak_idx;
    logic [IDX_W-1:0]  r_sig_idx;

    logic              r_s1_valid;
    logic              r_s1_last;
    logic [PROD_W-1:0] r_s1_prod;
    logic [POW_W-1:0]  r_s1_peak;
    logic [IDX_W-1:0]  r_s1_idx;
    logic [IDX_W-1:0]  r_s1_peak_idx;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_strong;
    logic [OUT_W-1:0]  r_out_sig;

    logic              en;
    logic              take;
    logic              retire;
    logic              new_peak;
    logic [POW_W-1:0]  n_peak;
    logic [IDX_W-1:0]  n_peak_idx;
    logic [RATIO_W-1:0] cfg_ratio;
    logic              sig_hit;
    logic [IDX_W-1:0]  n_sig_idx;
    logic [IDX_W+OUT_W-1:0] ext_strong;
    logic [IDX_W+OUT_W-1:0] ext_sig;

    // only a finishing frame can be held up, by a result not yet taken
    assign en     = !(r_s1_valid && r_s1_last && r_out_valid && !o_res.ready);
    assign o_pop  = en && i_entry_valid;
    assign take   = o_pop;
    assign retire = en && r_s1_valid;

    assign new_peak   = i_entry.power > r_peak;
    assign n_peak     = new_peak ? i_entry.power : r_peak;
    assign n_peak_idx = new_peak ? r_bin_cnt : r_peak_idx;

    // power * R^2 > peak * 2^16, peak already holding this bin
    assign sig_hit   = r_s1_prod > {{(PROD_W-POW_W-16){1'b0}}, r_s1_peak, 16'b0};
    assign n_sig_idx = sig_hit ? r_s1_idx : r_sig_idx;

    assign cfg_ratio   = (i_cfg.data == '0) ? DEFAULT_RATIO : i_cfg.data;
    assign i_cfg.ready = 1'b1;

    assign ext_strong = {{OUT_W{1'b0}}, r_s1_peak_idx};
    assign ext_sig    = {{OUT_W{1'b0}}, n_sig_idx};

    assign o_res.valid                   = r_out_valid;
    assign o_res.strongest_bin           = r_out_strong;
    assign o_res.highest_significant_bin = r_out_sig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsq       <= DEFAULT_RSQ;
            r_peak      <= '0;
            r_bin_cnt   <= '0;
            r_peak_idx  <= '0;
            r_sig_idx   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_rsq <= RSQ_W'(cfg_ratio) * RSQ_W'(cfg_ratio);
            end

            if (en) begin
                r_s1_valid <= i_entry_valid;
            end

            if (take) begin
                if (i_entry.last) begin
                    r_peak     <= '0;
                    r_bin_cnt  <= '0;
                    r_peak_idx <= '0;
                end else begin
                    r_peak     <= n_peak;
                    r_peak_idx <= n_peak_idx;
                    if (r_bin_cnt < LAST_IDX) begin
                        r_bin_cnt <= r_bin_cnt + 1'b1;
                    end
                end
            end

            if (retire && r_s1_last) begin
                r_sig_idx   <= '0;
                r_out_valid <= 1'b1;
            end else begin
                if (retire) begin
                    r_sig_idx <= n_sig_idx;
                end
                if (o_res.ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_last     <= i_entry.last;
            r_s1_prod     <= PROD_W'(i_entry.power) * PROD_W'(r_rsq);
            r_s1_peak     <= n_peak;
            r_s1_idx      <= r_bin_cnt;
            r_s1_peak_idx <= n_peak_idx;
        end
        if (retire && r_s1_last) begin
            r_out_strong <= ext_strong[OUT_W-1:0];
            r_out_sig    <= ext_sig[OUT_W-1:0];
        end
    end

    a_peak_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_entry.last && new_peak) |=> r_peak == $past(i_entry.power))
        else $error("peak not updated by a stronger bin");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_entry.last) |=> (r_peak == '0 && r_bin_cnt == '0))
        else $error("frame state not cleared after last bin");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (retire && r_s1_last) |=> r_out_valid)
        else $error("finished frame produced no result");

endmodule

### rtl/spectral_peak_and_significant_bin.sv
// ----------------------------------------------------------------------------
// spectral_peak_and_significant_bin
// Finds the strongest bin and the highest significant bin of each frame.
//
//   channel  | dir | payload                                    | transaction
//   i_bin    | in  | real_part, imag_part, last_bin             | one bin
//   o_res    | out | strongest_bin, highest_significant_bin     | one frame
//   i_cfg    | in  | data (ratio, Q8.8, 0 = 100)                | ratio write
//
// One bin per cycle sustained while the back end does not stall; after the
// last bin of a frame is accepted, its result goes from the queue into the
// multiply stage and is compared into the result register; squaring in the front is combinational.
// The 4-entry queue and the result register absorb back-pressure; only a
// frame end meeting an untaken result stalls the back end.
// Reset clears all frame state and sets the ratio to its default.
// ----------------------------------------------------------------------------
module spectral_peak_and_significant_bin
    import spb_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spb_bin_if.sink   i_bin,
    spb_cfg_if.sink   i_cfg,
    spb_res_if.source o_res
);

    logic   push;
    logic   full;
    logic   q_valid;
    logic   pop;
    t_entry push_entry;
    t_entry q_entry;

    spb_front u_front (
        .i_bin   (i_bin),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    spb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_entry),
        .i_pop   (pop)
    );

    spb_back #(
        .MAX_BINS (MAX_BINS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (i_cfg),
        .i_entry_valid (q_valid),
        .i_entry       (q_entry),
        .o_pop         (pop),
        .o_res         (o_res)
    );

endmodule

### test/spb_frame_checker.sv
// ----------------------------------------------------------------------------
// spb_frame_checker
// Watches the bin, ratio and result channels and keeps its own copy of the
// frame state. It works out the strongest and highest significant bin of
// every frame and checks each result transaction against the oldest
// outstanding frame.
// ----------------------------------------------------------------------------
module spb_frame_checker
    import spb_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    spb_bin_if   i_bin,
    spb_cfg_if   i_cfg,
    spb_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_frames_checked
);

    typedef struct packed {
        logic [OUT_W-1:0] strongest;
        logic [OUT_W-1:0] significant;
    } t_frame_result;

    t_frame_result      frame_results_q[$];
    logic [RATIO_W-1:0] ratio;
    logic [POW_W-1:0]   peak_power;
    int                 bin_idx;
    int                 peak_idx;
    int                 sig_idx;
    int                 fail_count;
    int                 frames_checked;

    always @(posedge i_clk) begin : track
        longint             sq;
        logic [POW_W-1:0]   pwr;
        logic [RATIO_W-1:0] r;
        logic [PROD_W-1:0]  lhs;
        logic [PROD_W-1:0]  rhs;
        t_frame_result      got;
        t_frame_result      want;
        t_frame_result      done;
        if (!i_rst_n) begin
            ratio      = '0;
            peak_power = '0;
            bin_idx    = 0;
            peak_idx   = 0;
            sig_idx    = 0;
            frame_results_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                ratio = i_cfg.data;

            // result first, so a frame closing on this edge is not taken by it
            if (i_res.valid && i_res.ready) begin
                got.strongest   = i_res.strongest_bin;
                got.significant = i_res.highest_significant_bin;
                if (frame_results_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got strongest_bin %0d highest_significant_bin %0d",
                             $time, got.strongest, got.significant);
                    fail_count++;
                end else begin
                    want = frame_results_q.pop_front();
                    if (got.strongest !== want.strongest) begin
                        $display("%0t: strongest_bin expected %0d, got %0d",
                                 $time, want.strongest, got.strongest);
                        fail_count++;
                    end
                    if (got.significant !== want.significant) begin
                        $display("%0t: highest_significant_bin expected %0d, got %0d",
                                 $time, want.significant, got.significant);
                        fail_count++;
                    end
                    frames_checked++;
                end
            end

            if (i_bin.valid && i_bin.ready) begin
                sq  = longint'(i_bin.real_part) * i_bin.real_part
                    + longint'(i_bin.imag_part) * i_bin.imag_part;
                pwr = sq[POW_W-1:0];
                r   = (ratio == '0) ? DEFAULT_RATIO : ratio;
                if (pwr > peak_power) begin
                    peak_power = pwr;
                    peak_idx   = bin_idx;
                end
                // mag > max / (r/256)  <=>  pwr * r^2 > peak * 2^16, peak incl. this bin
                lhs = PROD_W'(pwr) * (PROD_W'(r) * PROD_W'(r));
                rhs = PROD_W'(peak_power) << 16;
                if (lhs > rhs)
                    sig_idx = bin_idx;
                if (bin_idx < MAX_BINS - 1)
                    bin_idx++;
                if (i_bin.last_bin) begin
                    done.strongest   = OUT_W'(peak_idx);
                    done.significant = OUT_W'(sig_idx);
                    frame_results_q.push_back(done);
                    peak_power = '0;
                    bin_idx    = 0;
                    peak_idx   = 0;
                    sig_idx    = 0;
                end
            end
        end
        o_fail_count     <= fail_count;
        o_pending        <= frame_results_q.size();
        o_frames_checked <= frames_checked;
    end

endmodule

### test/spectral_peak_and_significant_bin_tb.sv
// ----------------------------------------------------------------------------
// spectral_peak_and_significant_bin_tb
// Drives bins and ratio writes into the spectral peak block and gives the
// verdict. A short directed set covers extremes, ties, silent frames and the
// significance threshold; random frames then run under several ratios and
// idle patterns, with one long result hold-off.
// ----------------------------------------------------------------------------
module spectral_peak_and_significant_bin_tb;
    import spb_pkg::*;

    localparam int RANDOM_ITEMS  = 560;
    localparam int PHASES        = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic signed [DATA_W-1:0] MOST_NEG = 16'sh8000;
    localparam logic signed [DATA_W-1:0] MOST_POS = 16'sh7FFF;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SOURCE,
        IDLE_SINK,
        IDLE_BOTH
    } t_idle_mode;

    logic clk;
    logic rst_n;
    logic hold_req = 1'b0;
    int   src_idle_pct = 0;
    int   snk_stall_pct = 0;
    int   cycle_count = 0;
    int   bins_sent = 0;
    int   ratio_writes = 0;
    int   fail_count;
    int   pending;
    int   frames_checked;

    spb_bin_if bin_ch ();
    spb_cfg_if cfg_ch ();
    spb_res_if res_ch ();

    spectral_peak_and_significant_bin #(
        .MAX_BINS (MAX_BINS_DEF)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_bin   (bin_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    spb_frame_checker #(
        .MAX_BINS (MAX_BINS_DEF)
    ) checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_bin            (bin_ch),
        .i_cfg            (cfg_ch),
        .i_res            (res_ch),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_frames_checked (frames_checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout with %0d frame results outstanding", $time, pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls, or a long hold-off on request
    initial begin : sink_ready
        int held;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge clk);
                    held++;
                end
                hold_req = 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            IDLE_SOURCE: begin
                src_idle_pct  = 53;
                snk_stall_pct = 0;
            end
            IDLE_SINK: begin
                src_idle_pct  = 0;
                snk_stall_pct = 53;
            end
            default: begin
                src_idle_pct  = 31;
                snk_stall_pct = 31;
            end
        endcase
    endtask

    task automatic send_bin(input logic signed [DATA_W-1:0] re,
                            input logic signed [DATA_W-1:0] im,
                            input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            bin_ch.valid <= 1'b0;
            @(posedge clk);
        end
        bin_ch.valid     <= 1'b1;
        bin_ch.real_part <= re;
        bin_ch.imag_part <= im;
        bin_ch.last_bin  <= last;
        do @(posedge clk); while (!bin_ch.ready);
        bins_sent++;
    endtask

    // mix of full-range, small, extreme and repeated parts (the last gives ties)
    function automatic logic signed [DATA_W-1:0] pick_part(
            input logic signed [DATA_W-1:0] anchor);
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return DATA_W'($urandom);
        else if (sel < 60)
            return DATA_W'(int'($urandom_range(63)) - 32);
        else if (sel < 70) begin
            case ($urandom_range(3))
                0:       return MOST_NEG;
                1:       return MOST_POS;
                2:       return '0;
                default: return '1;
            endcase
        end else if ($urandom_range(1) == 1)
            return -anchor;
        else
            return anchor;
    endfunction

    function automatic int frame_len();
        int sel;
        sel = $urandom_range(99);
        if (sel < 75)
            return $urandom_range(1, 8);
        else if (sel < 95)
            return $urandom_range(9, 40);
        else
            return $urandom_range(41, 120);
    endfunction

    task automatic send_frame(input int len, input logic close);
        logic signed [DATA_W-1:0] anchor;
        anchor = DATA_W'($urandom);
        for (int i = 0; i < len; i++)
            send_bin(pick_part(anchor), pick_part(anchor), close && (i == len - 1));
    endtask

    // no transaction in flight, every frame result taken, pipeline empty
    task automatic settle();
        bin_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_ratio(input logic [RATIO_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        ratio_writes++;
    endtask

    initial begin : stimulus
        logic [RATIO_W-1:0] phase_ratio [PHASES];
        int                 items;
        int                 len;

        rst_n            <= 1'b0;
        bin_ch.valid     <= 1'b0;
        bin_ch.real_part <= '0;
        bin_ch.imag_part <= '0;
        bin_ch.last_bin  <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.data      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default ratio after reset
        set_idle(IDLE_NONE);
        // silent frame
        send_bin(16'sd0, 16'sd0, 1'b0);
        send_bin(16'sd0, 16'sd0, 1'b0);
        send_bin(16'sd0, 16'sd0, 1'b1);
        // single-bin frame at full power
        send_bin(MOST_NEG, MOST_NEG, 1'b1);
        // extremes; equal powers on the first two bins
        send_bin(MOST_POS, MOST_NEG, 1'b0);
        send_bin(MOST_NEG, MOST_POS, 1'b0);
        send_bin(MOST_NEG, MOST_NEG, 1'b0);
        send_bin(16'sd1, 16'sd0, 1'b0);
        send_bin(16'sd0, -16'sd1, 1'b1);
        // ties: first maximum stays
        send_bin(16'sd100, 16'sd0, 1'b0);
        send_bin(16'sd0, 16'sd100, 1'b0);
        send_bin(-16'sd100, 16'sd0, 1'b0);
        send_bin(16'sd0, -16'sd100, 1'b1);
        // around max/100: 11 passes, exactly 10 and 9 do not
        send_bin(16'sd1000, 16'sd0, 1'b0);
        send_bin(16'sd11, 16'sd0, 1'b0);
        send_bin(16'sd10, 16'sd0, 1'b0);
        send_bin(16'sd0, -16'sd9, 1'b1);
        settle();

        // ratio below one: a new peak may fail its own test
        write_ratio(16'd128);
        send_bin(16'sd5, 16'sd0, 1'b0);
        send_bin(16'sd10, 16'sd0, 1'b1);
        send_bin(MOST_POS, MOST_POS, 1'b0);
        send_bin(16'sd3, 16'sd4, 1'b1);
        settle();

        phase_ratio[0] = 16'hFFFF;
        phase_ratio[1] = 16'd1;
        phase_ratio[2] = 16'd256;
        phase_ratio[3] = 16'd0;
        phase_ratio[4] = 16'd300;
        phase_ratio[5] = RATIO_W'($urandom_range(257, 4000));
        phase_ratio[6] = RATIO_W'($urandom);
        phase_ratio[7] = DEFAULT_RATIO;

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_ratio(phase_ratio[p]);
            set_idle(t_idle_mode'(p % 4));
            // hold results off for a while so the block backs up onto its input
            if (p == 4)
                hold_req = 1'b1;
            items = 0;
            while (items < RANDOM_ITEMS / PHASES) begin
                len = frame_len();
                send_frame(len, 1'b1);
                items += len;
            end
        end

        settle();
        $display("Covered %0d bins over %0d checked frames with %0d ratio writes,",
                 bins_sent, frames_checked, ratio_writes);
        $display("four idle patterns and a long result hold-off.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
